// ===== hw/rtl/magnetometer_average_minmax_calibrate_assert.svh =====
// Assertion macros for the magnetometer averaging and calibration block.
// Included by the top level only; no other dependencies.
`ifndef MAGNETOMETER_AVERAGE_MINMAX_CALIBRATE_ASSERT_SVH
`define MAGNETOMETER_AVERAGE_MINMAX_CALIBRATE_ASSERT_SVH

// Same-cycle implication under reset.
`define MACAL_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("macal assertion failed");

// Next-cycle implication under reset.
`define MACAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("macal assertion failed");

`endif

// ===== hw/rtl/macal_pkg.sv =====
// Shared types and constants for the magnetometer averaging block.
// No dependencies; used by the interfaces, the multiplier and the top level.
package macal_pkg;

    localparam int WORD_W      = 16;
    localparam int CAL_W       = 24;
    localparam int MUL_W       = 26;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int RECIP_SHIFT = 24;
    localparam int Q_W         = 17;
    localparam int DIFF_W      = 17;
    localparam int CAL_SHIFT   = 8;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z  = 3'd5;

    localparam logic signed [WORD_W-1:0] SCALE_UNITY = 16'sd4096;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_LAST = AXIS_Z;

    typedef struct packed {
        logic                     en;
        logic signed [MUL_W-1:0]  a;
        logic signed [MUL_W-1:0]  b;
    } mul_req_t;

endpackage

// ===== hw/rtl/macal_if.sv =====
// Handshake interfaces for sample input and result output.
// Depends on macal_pkg for field widths.
interface macal_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [macal_pkg::WORD_W-1:0]   first_word;
    logic signed [macal_pkg::WORD_W-1:0]   middle_word;
    logic signed [macal_pkg::WORD_W-1:0]   last_word;

    modport source (output valid, first_word, middle_word, last_word, input ready);
    modport sink   (input valid, first_word, middle_word, last_word, output ready);
endinterface

interface macal_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [macal_pkg::WORD_W-1:0]   avg_x;
    logic signed [macal_pkg::WORD_W-1:0]   avg_y;
    logic signed [macal_pkg::WORD_W-1:0]   avg_z;
    logic signed [macal_pkg::WORD_W-1:0]   min_x;
    logic signed [macal_pkg::WORD_W-1:0]   min_y;
    logic signed [macal_pkg::WORD_W-1:0]   min_z;
    logic signed [macal_pkg::WORD_W-1:0]   max_x;
    logic signed [macal_pkg::WORD_W-1:0]   max_y;
    logic signed [macal_pkg::WORD_W-1:0]   max_z;
    logic signed [macal_pkg::CAL_W-1:0]    cal_x;
    logic signed [macal_pkg::CAL_W-1:0]    cal_y;
    logic signed [macal_pkg::CAL_W-1:0]    cal_z;

    modport source (output valid, avg_x, avg_y, avg_z, min_x, min_y, min_z,
                    max_x, max_y, max_z, cal_x, cal_y, cal_z, input ready);
    modport sink   (input valid, avg_x, avg_y, avg_z, min_x, min_y, min_z,
                    max_x, max_y, max_z, cal_x, cal_y, cal_z, output ready);
endinterface

// ===== hw/rtl/macal_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on macal_pkg (mul_req_t, widths).
module macal_mul
(
    input  logic                                    clk,
    input  macal_pkg::mul_req_t                     req,
    output logic signed [macal_pkg::PROD_W-1:0]     prod
);

    logic signed [macal_pkg::PROD_W-1:0] prod_reg;
    logic signed [macal_pkg::PROD_W-1:0] prod_next;

    assign prod_next = macal_pkg::PROD_W'(req.a) * macal_pkg::PROD_W'(req.b);

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/magnetometer_average_minmax_calibrate.sv =====
// Magnetometer window average, min/max tracking and offset/scale calibration.
// A sample transaction runs six sequencer steps per axis over three axes, then
// one done step that loads the result register. Not ready while a sample is in
// work; a held result stalls S_DONE.
// Reset (rst_n low, async): window emptied, sums, min/max cleared, scales unity.
// Depends on macal_pkg, macal_if, macal_mul and the assertion header.
`include "magnetometer_average_minmax_calibrate_assert.svh"

module magnetometer_average_minmax_calibrate
#(
    parameter int WINDOW_LEN = 10
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [macal_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [macal_pkg::WORD_W-1:0]          cfg_data,
    macal_in_if.sink                              sample,
    macal_out_if.source                           result
);

    // Window is a circular buffer; ptr marks the oldest slot. Until the
    // pointer first wraps, the slot being replaced was never written and
    // counts as zero, so a single "full" flag stands in for valid bits.
    localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    // Running sum spans +/- WINDOW_LEN * 32768.
    localparam int SUM_W = 17 + $clog2(WINDOW_LEN);
    // Reciprocal for divide by WINDOW_LEN: estimate is exact or one low.
    localparam int RECIP = (1 << macal_pkg::RECIP_SHIFT) / WINDOW_LEN;

    localparam int W = macal_pkg::WORD_W;

    typedef enum logic [7:0]
    {
        S_IDLE = 8'b0000_0001,
        S_SUM  = 8'b0000_0010,
        S_MULQ = 8'b0000_0100,
        S_MULR = 8'b0000_1000,
        S_FIX  = 8'b0001_0000,
        S_MULC = 8'b0010_0000,
        S_CAL  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    typedef logic [2:0][W-1:0] row_t;   // [0]=x, [1]=y, [2]=z

    state_t                         state_reg, state_next;
    logic [1:0]                     axis_reg;
    logic [PTR_W-1:0]               ptr_reg;
    logic                           full_reg;
    logic                           old_valid_reg;

    row_t                           mem [WINDOW_LEN];
    row_t                           rd_row_reg;
    row_t                           new_row_reg;
    row_t                           sample_row;

    logic signed [SUM_W-1:0]        sum_reg [3];
    logic signed [W-1:0]            avg_reg [3];
    logic signed [W-1:0]            min_reg [3];
    logic signed [W-1:0]            max_reg [3];
    logic signed [macal_pkg::CAL_W-1:0] cal_reg [3];
    logic [macal_pkg::Q_W-1:0]      q_reg;

    logic signed [W-1:0]            offset_reg [3];
    logic signed [W-1:0]            scale_reg [3];

    // result register
    logic                           out_valid_reg;
    logic signed [W-1:0]            o_avg_reg [3];
    logic signed [W-1:0]            o_min_reg [3];
    logic signed [W-1:0]            o_max_reg [3];
    logic signed [macal_pkg::CAL_W-1:0] o_cal_reg [3];

    logic                           accept;
    logic                           load_out;
    logic signed [SUM_W-1:0]        sum_cur;
    logic [SUM_W-1:0]               sum_abs;
    logic signed [W-1:0]            old_word;
    logic signed [SUM_W-1:0]        sum_next;
    logic [SUM_W-1:0]               rem;
    logic [macal_pkg::Q_W-1:0]      q_fix;
    logic signed [W-1:0]            avg_next;
    logic signed [macal_pkg::DIFF_W-1:0] diff;
    macal_pkg::mul_req_t            mul_req;
    logic signed [macal_pkg::PROD_W-1:0] prod;

    assign accept       = sample.valid && sample.ready;
    assign sample.ready = (state_reg == S_IDLE);
    assign load_out     = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    // Axis remap: x from last word, y from negated first word (16-bit wrap).
    assign sample_row[0] = sample.last_word;
    assign sample_row[1] = W'(-sample.first_word);
    assign sample_row[2] = sample.middle_word;

    // ---------------------------------------------------------------
    // Window memory: one row per slot, read-before-write on accept
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_row_reg    <= mem[ptr_reg];
            mem[ptr_reg]  <= sample_row;
            new_row_reg   <= sample_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            full_reg      <= 1'b0;
            old_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            old_valid_reg <= full_reg;
            if (ptr_reg == PTR_W'(WINDOW_LEN - 1))
            begin
                ptr_reg  <= '0;
                full_reg <= 1'b1;
            end
            else
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Per-axis datapath
    // ---------------------------------------------------------------
    assign sum_cur  = sum_reg[axis_reg];
    assign sum_abs  = sum_cur[SUM_W-1] ? SUM_W'(-sum_cur) : SUM_W'(sum_cur);
    assign old_word = old_valid_reg ? $signed(rd_row_reg[axis_reg]) : '0;
    assign sum_next = sum_cur - SUM_W'(old_word)
                      + SUM_W'($signed(new_row_reg[axis_reg]));

    // remainder after the estimated quotient; bump by one if still >= N
    assign rem      = sum_abs - prod[SUM_W-1:0];
    assign q_fix    = (rem >= SUM_W'(WINDOW_LEN)) ? q_reg + 1'b1 : q_reg;
    assign avg_next = sum_cur[SUM_W-1] ? W'(-q_fix) : W'(q_fix);

    assign diff = macal_pkg::DIFF_W'(avg_reg[axis_reg])
                  - macal_pkg::DIFF_W'(offset_reg[axis_reg]);

    always_comb
    begin
        mul_req.en = 1'b0;
        mul_req.a  = '0;
        mul_req.b  = '0;
        case (state_reg)
            S_MULQ:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = macal_pkg::MUL_W'(sum_abs);
                mul_req.b  = macal_pkg::MUL_W'(RECIP);
            end
            S_MULR:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = macal_pkg::MUL_W'(prod[macal_pkg::RECIP_SHIFT +: macal_pkg::Q_W]);
                mul_req.b  = macal_pkg::MUL_W'(WINDOW_LEN);
            end
            S_MULC:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = macal_pkg::MUL_W'(diff);
                mul_req.b  = macal_pkg::MUL_W'(scale_reg[axis_reg]);
            end
            default:
            begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    macal_mul u_mul
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_SUM;
            S_SUM:  state_next = S_MULQ;
            S_MULQ: state_next = S_MULR;
            S_MULR: state_next = S_FIX;
            S_FIX:  state_next = S_MULC;
            S_MULC: state_next = S_CAL;
            S_CAL:  state_next = (axis_reg == macal_pkg::AXIS_LAST) ? S_DONE : S_SUM;
            S_DONE: if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= macal_pkg::AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                axis_reg <= macal_pkg::AXIS_X;
            end
            else if (state_reg == S_CAL && axis_reg != macal_pkg::AXIS_LAST)
            begin
                axis_reg <= axis_reg + 1'b1;
            end
        end
    end

    // sums and min/max are architectural state: reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a] <= '0;
                min_reg[a] <= '0;
                max_reg[a] <= '0;
            end
        end
        else
        begin
            if (state_reg == S_SUM)
            begin
                sum_reg[axis_reg] <= sum_next;
            end
            if (state_reg == S_FIX)
            begin
                if (avg_next < min_reg[axis_reg])
                begin
                    min_reg[axis_reg] <= avg_next;
                end
                if (avg_next > max_reg[axis_reg])
                begin
                    max_reg[axis_reg] <= avg_next;
                end
            end
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MULR)
        begin
            q_reg <= prod[macal_pkg::RECIP_SHIFT +: macal_pkg::Q_W];
        end
        if (state_reg == S_FIX)
        begin
            avg_reg[axis_reg] <= avg_next;
        end
        if (state_reg == S_CAL)
        begin
            // arithmetic shift right 8 (floor), keeps 4 fraction bits
            cal_reg[axis_reg] <= prod[macal_pkg::CAL_SHIFT +: macal_pkg::CAL_W];
        end
    end

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                offset_reg[a] <= '0;
                scale_reg[a]  <= macal_pkg::SCALE_UNITY;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                macal_pkg::CFG_OFFSET_X: offset_reg[0] <= cfg_data;
                macal_pkg::CFG_OFFSET_Y: offset_reg[1] <= cfg_data;
                macal_pkg::CFG_OFFSET_Z: offset_reg[2] <= cfg_data;
                macal_pkg::CFG_SCALE_X:  scale_reg[0]  <= cfg_data;
                macal_pkg::CFG_SCALE_Y:  scale_reg[1]  <= cfg_data;
                macal_pkg::CFG_SCALE_Z:  scale_reg[2]  <= cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            for (int a = 0; a < 3; a++)
            begin
                o_avg_reg[a] <= avg_reg[a];
                o_min_reg[a] <= min_reg[a];
                o_max_reg[a] <= max_reg[a];
                o_cal_reg[a] <= cal_reg[a];
            end
        end
    end

    assign result.valid = out_valid_reg;
    assign result.avg_x = o_avg_reg[0];
    assign result.avg_y = o_avg_reg[1];
    assign result.avg_z = o_avg_reg[2];
    assign result.min_x = o_min_reg[0];
    assign result.min_y = o_min_reg[1];
    assign result.min_z = o_min_reg[2];
    assign result.max_x = o_max_reg[0];
    assign result.max_y = o_max_reg[1];
    assign result.max_z = o_max_reg[2];
    assign result.cal_x = o_cal_reg[0];
    assign result.cal_y = o_cal_reg[1];
    assign result.cal_z = o_cal_reg[2];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `MACAL_ASSERT_HOLDS(a_out_bounds, clk, rst_n, result.valid,
        (result.min_x <= result.avg_x) && (result.avg_x <= result.max_x) &&
        (result.min_y <= result.avg_y) && (result.avg_y <= result.max_y) &&
        (result.min_z <= result.avg_z) && (result.avg_z <= result.max_z))
    `MACAL_ASSERT_HOLDS(a_minmax_sign, clk, rst_n, 1'b1,
        (min_reg[0] <= 0) && (min_reg[1] <= 0) && (min_reg[2] <= 0) &&
        (max_reg[0] >= 0) && (max_reg[1] >= 0) && (max_reg[2] >= 0))
    `MACAL_ASSERT_NEXT(a_accept_start, clk, rst_n, accept,
        (state_reg == S_SUM) && (axis_reg == macal_pkg::AXIS_X))
    `MACAL_ASSERT_HOLDS(a_done_all_axes, clk, rst_n, state_reg == S_DONE,
        axis_reg == macal_pkg::AXIS_LAST)

endmodule
